// File: rtl/ats_pkg.sv
// Package for the alias-table sampler: sizes, operation codes, status codes,
// a register address and the controller state type. No dependencies.
package ats_pkg;

    localparam int unsigned MAX_CLASSES = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned THR_W       = 44;
    localparam int unsigned SUM_W       = 42;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLASSES);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam logic [PADDR_W-3:0] REG_CLASS_COUNT = '0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD,
        S_B_CMP,
        S_P_RK,
        S_P_RT,
        S_P_RA,
        S_P_RB,
        S_P_UPD,
        S_D_MUL,
        S_D_PROD,
        S_D_OUT
    } t_state;

endpackage

// File: rtl/ats_req_if.sv
// Request channel of the sampler: valid/ready handshake plus load/draw payload.
// Depends on ats_pkg for field widths.
interface ats_req_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [ats_pkg::DATA_W-1:0] weight;
    logic [ats_pkg::DATA_W-1:0] uniform_fraction;

    modport source (output valid, operation, weight, uniform_fraction, input ready);
    modport sink   (input valid, operation, weight, uniform_fraction, output ready);
endinterface

// Result channel of the sampler: one result per draw request.
interface ats_res_if;
    logic                      valid;
    logic                      ready;
    logic [ats_pkg::IDX_W-1:0] class_index;
    logic                      status;

    modport source (output valid, class_index, status, input ready);
    modport sink   (input valid, class_index, status, output ready);
endinterface

// File: rtl/alias_table_sampler_core.sv
// Walker alias-method sampler: weight loading, table build and draws.
// Depends on ats_pkg and the ats_req_if / ats_res_if interfaces.
//
// A load request writes weight*n into the threshold memory. The n-th
// load starts the table build, which holds off requests while it
// classifies the classes one by one and then runs the pairing steps (at
// most n-1 steps); every step is a chain of memory reads followed by a
// read-modify-write of one threshold entry. A draw multiplies u*n and
// reads both tables, forms frac*sum in two multipliers, then compares and
// loads the output register. Draws made before a table is built, or with
// a zero weight sum, return status 1 and class 0. Writing class_count
// drops any table and any load round.
module alias_table_sampler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ats_req_if.sink                       i_req,
    ats_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ats_pkg::PADDR_W-1:0]   paddr,
    input  logic [ats_pkg::DATA_W-1:0]    pwdata,
    output logic [ats_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import ats_pkg::*;

    logic [THR_W-1:0] r_thr_mem [MAX_CLASSES];
    logic [IDX_W-1:0] r_alias_mem [MAX_CLASSES];
    logic [IDX_W-1:0] r_wl_mem [MAX_CLASSES];

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count, r_load_cnt, r_i, r_ns, r_nl, r_k, r_top;
    logic [SUM_W-1:0] r_sum;
    logic             r_tready;
    logic [IDX_W-1:0] r_a, r_b;
    logic [THR_W-1:0] r_thr_a, r_thr_k;
    logic [IDX_W-1:0] r_alias_k;
    logic [DATA_W-1:0] r_u, r_f;
    logic [2*DATA_W-1:0] r_plo;
    logic [SUM_W-1:0] r_phi;
    logic             r_ovalid, r_ostat;
    logic [IDX_W-1:0] r_oidx;

    // memory ports
    logic             thr_we;
    logic [IDX_W-1:0] thr_waddr, thr_raddr;
    logic [THR_W-1:0] thr_wdata, r_thr_rd;
    logic             al_we;
    logic [IDX_W-1:0] al_waddr, al_wdata, al_raddr, r_al_rd;
    logic             wl_we;
    logic [IDX_W-1:0] wl_waddr, wl_wdata, wl_raddr, r_wl_rd;

    logic             req_acc, cfg_wr, out_free;
    logic [CNT_W-1:0] load_next, k_next, top_next, cfg_val;
    logic [DATA_W+CNT_W-1:0] draw_t;
    logic [THR_W-1:0] deficit, thr_b_new;
    logic [SUM_W:0]   hi;

    assign req_acc  = i_req.valid && i_req.ready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_CLASS_COUNT);
    assign out_free = !r_ovalid || o_res.ready;
    assign pready   = 1'b1;
    assign prdata   = {{(DATA_W-CNT_W){1'b0}}, r_count};

    assign cfg_val = (pwdata[CNT_W-1:0] == '0)     ? CNT_W'(1) :
                     (pwdata[CNT_W-1:0] > CNT_MAX) ? CNT_MAX : pwdata[CNT_W-1:0];

    assign load_next = r_load_cnt + CNT_W'(1);
    assign draw_t    = {{CNT_W{1'b0}}, r_u} * {{DATA_W{1'b0}}, r_count};
    assign deficit   = {{(THR_W-SUM_W){1'b0}}, r_sum} - r_thr_a;
    assign thr_b_new = (r_thr_rd >= deficit) ? (r_thr_rd - deficit) : '0;
    assign top_next  = r_top + CNT_W'(thr_b_new < {{(THR_W-SUM_W){1'b0}}, r_sum});
    assign k_next    = r_k + CNT_W'(1);
    assign hi        = {1'b0, SUM_W'(r_plo[2*DATA_W-1:DATA_W]) + r_phi};

    // hold off a request outside idle and while a register write lands
    assign i_req.ready     = (r_state == S_IDLE) && !cfg_wr;
    assign o_res.valid     = r_ovalid;
    assign o_res.class_index = r_oidx;
    assign o_res.status    = r_ostat;

    always_comb begin
        n_state   = r_state;
        thr_we    = 1'b0;
        thr_waddr = r_load_cnt[IDX_W-1:0];
        thr_wdata = THR_W'(i_req.weight) * THR_W'(r_count);
        thr_raddr = r_i[IDX_W-1:0];
        al_we     = 1'b0;
        al_waddr  = r_i[IDX_W-1:0];
        al_wdata  = r_i[IDX_W-1:0];
        al_raddr  = draw_t[DATA_W+IDX_W-1:DATA_W];
        wl_we     = 1'b0;
        wl_waddr  = r_ns[IDX_W-1:0];
        wl_wdata  = r_i[IDX_W-1:0];
        wl_raddr  = r_k[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.operation == OP_LOAD) begin
                        thr_we = 1'b1;
                        if (load_next >= r_count) n_state = S_B_RD;
                    end else begin
                        n_state = S_D_MUL;
                    end
                end
            end
            S_B_RD: begin
                al_we   = 1'b1;
                n_state = S_B_CMP;
            end
            S_B_CMP: begin
                wl_we = 1'b1;
                if (r_thr_rd >= {{(THR_W-SUM_W){1'b0}}, r_sum}) begin
                    wl_waddr = IDX_W'(r_nl - CNT_W'(1));
                end
                if (r_i + CNT_W'(1) < r_count) begin
                    n_state = S_B_RD;
                end else begin
                    // top is nl after this element; pairing needs both lists
                    n_state = S_IDLE;
                    if (r_thr_rd < {{(THR_W-SUM_W){1'b0}}, r_sum}) begin
                        if (r_nl < r_count && r_count > CNT_W'(1)) n_state = S_P_RK;
                    end else begin
                        if (r_nl - CNT_W'(1) != '0) n_state = S_P_RK;
                    end
                end
            end
            S_P_RK: begin
                wl_raddr = r_k[IDX_W-1:0];
                n_state  = S_P_RT;
            end
            S_P_RT: begin
                wl_raddr = r_top[IDX_W-1:0];
                n_state  = S_P_RA;
            end
            S_P_RA: begin
                thr_raddr = r_a;
                n_state   = S_P_RB;
            end
            S_P_RB: begin
                thr_raddr = r_b;
                al_we     = 1'b1;
                al_waddr  = r_a;
                al_wdata  = r_b;
                n_state   = S_P_UPD;
            end
            S_P_UPD: begin
                thr_we    = 1'b1;
                thr_waddr = r_b;
                thr_wdata = thr_b_new;
                if (top_next >= r_count) n_state = S_IDLE;
                else if (k_next + CNT_W'(1) < r_count && k_next < top_next) n_state = S_P_RK;
                else n_state = S_IDLE;
            end
            S_D_MUL: begin
                thr_raddr = draw_t[DATA_W+IDX_W-1:DATA_W];
                n_state   = S_D_PROD;
            end
            S_D_PROD: begin
                n_state = S_D_OUT;
            end
            S_D_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (thr_we) r_thr_mem[thr_waddr] <= thr_wdata;
        r_thr_rd <= r_thr_mem[thr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (al_we) r_alias_mem[al_waddr] <= al_wdata;
        r_al_rd <= r_alias_mem[al_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wl_we) r_wl_mem[wl_waddr] <= wl_wdata;
        r_wl_rd <= r_wl_mem[wl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CNT_MAX;
            r_load_cnt <= '0;
            r_sum      <= '0;
            r_tready   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_state == S_D_OUT && out_free) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
            if (cfg_wr) begin
                r_count    <= cfg_val;
                r_load_cnt <= '0;
                r_sum      <= '0;
                r_tready   <= 1'b0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (req_acc) begin
                            if (i_req.operation == OP_LOAD) begin
                                if (r_load_cnt == '0) begin
                                    r_sum    <= SUM_W'(i_req.weight);
                                    r_tready <= 1'b0;
                                end else begin
                                    r_sum <= r_sum + SUM_W'(i_req.weight);
                                end
                                if (load_next >= r_count) begin
                                    r_load_cnt <= '0;
                                    r_i        <= '0;
                                    r_ns       <= '0;
                                    r_nl       <= r_count;
                                    r_k        <= '0;
                                end else begin
                                    r_load_cnt <= load_next;
                                end
                            end else begin
                                r_u <= i_req.uniform_fraction;
                            end
                        end
                    end
                    S_B_CMP: begin
                        r_i <= r_i + CNT_W'(1);
                        if (r_thr_rd < {{(THR_W-SUM_W){1'b0}}, r_sum}) begin
                            r_ns <= r_ns + CNT_W'(1);
                            r_top <= r_nl;
                        end else begin
                            r_nl  <= r_nl - CNT_W'(1);
                            r_top <= r_nl - CNT_W'(1);
                        end
                        if (n_state == S_IDLE) r_tready <= 1'b1;
                    end
                    S_P_RT: r_a <= r_wl_rd;
                    S_P_RA: r_b <= r_wl_rd;
                    S_P_RB: r_thr_a <= r_thr_rd;
                    S_P_UPD: begin
                        r_top <= top_next;
                        r_k   <= k_next;
                        if (n_state == S_IDLE) r_tready <= 1'b1;
                    end
                    S_D_MUL: begin
                        r_a <= draw_t[DATA_W+IDX_W-1:DATA_W];
                        r_f <= draw_t[DATA_W-1:0];
                    end
                    S_D_PROD: begin
                        r_plo     <= {{DATA_W{1'b0}}, r_f} *
                                     {{DATA_W{1'b0}}, r_sum[DATA_W-1:0]};
                        r_phi     <= SUM_W'(r_f) * SUM_W'(r_sum[SUM_W-1:DATA_W]);
                        r_thr_k   <= r_thr_rd;
                        r_alias_k <= r_al_rd;
                    end
                    S_D_OUT: begin
                        if (out_free) begin
                            if (!r_tready || r_sum == '0) begin
                                r_ostat <= ST_ERR;
                                r_oidx  <= '0;
                            end else begin
                                r_ostat <= ST_OK;
                                r_oidx  <= ({1'b0, hi} < r_thr_k) ? r_a : r_alias_k;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/ats_checker.sv
// Port-level checker for the alias-table sampler, bound to the top level.
// Depends on ats_pkg for widths and status codes.
module ats_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ats_pkg::IDX_W-1:0]   i_out_idx,
    input logic                        i_out_status,
    input logic                        i_pready
);
    import ats_pkg::*;

    // an error result always names class zero
    a_err_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == ST_ERR) |-> (i_out_idx == '0))
        else $error("error result with nonzero class");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_idx)
            && $stable(i_out_status)))
        else $error("result changed while stalled");

    // a new result never shows up right after a request is accepted
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result raised too early");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");

    // no result in the first cycle after reset is released
    a_rst_out: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind alias_table_sampler_core ats_checker u_ats_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_idx    (o_res.class_index),
    .i_out_status (o_res.status),
    .i_pready     (pready)
);

// File: verif/alias_table_sampler_core_tb.sv
// Self-checking testbench for alias_table_sampler_core: loads weight rounds,
// draws samples and compares each result against a built-in alias-table model.
// Depends on ats_pkg and the ats_req_if / ats_res_if interfaces.
`timescale 1ns / 1ps

module alias_table_sampler_core_tb;
    import ats_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] class_index;
        logic             status;
    } sample_t;

    localparam longint unsigned CYCLE_LIMIT = 3_000_000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    ats_req_if req_if ();
    ats_res_if res_if ();

    alias_table_sampler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // sampler model state
    bit [63:0]      thr_tab [MAX_CLASSES];
    bit [IDX_W-1:0] alias_tab [MAX_CLASSES];
    bit [IDX_W-1:0] work_tab [MAX_CLASSES];
    bit [63:0]      sum_w;
    int unsigned    loads_seen;
    bit             tab_ready;
    int unsigned    n_classes;

    sample_t     pending_samples [$];
    int unsigned mismatches;
    int unsigned samples_checked;
    int unsigned err_samples;
    int unsigned tables_built;
    int unsigned requests_sent;
    longint unsigned cycles;
    bit src_idle;
    bit snk_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("alias_table_sampler_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
        mismatches++;
    endtask

    // result side: check on handshake, then pick the next ready value
    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected result, class", -1, res_if.class_index);
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (res_if.status !== want.status)
                    report_mismatch("status", want.status, res_if.status);
                if (res_if.class_index !== want.class_index)
                    report_mismatch("class_index", want.class_index, res_if.class_index);
            end
        end
        res_if.ready <= !(snk_idle && $urandom_range(99) < 47);
    end

    function automatic int unsigned clamp_classes(input bit [31:0] v);
        bit [10:0] c;
        c = v[10:0];
        if (c == 0) return 1;
        if (c > MAX_CLASSES) return MAX_CLASSES;
        return c;
    endfunction

    function automatic void build_alias_table();
        int unsigned n_small, n_large, top, a, b;
        bit [63:0] deficit;
        n_small = 0;
        n_large = n_classes;
        for (int unsigned i = 0; i < n_classes; i++) begin
            alias_tab[i] = i;
            if (thr_tab[i] < sum_w) begin
                work_tab[n_small] = i;
                n_small++;
            end else begin
                n_large--;
                work_tab[n_large] = i;
            end
        end
        top = n_large;
        if (n_small > 0 && top < n_classes) begin
            for (int unsigned k = 0; k + 1 < n_classes; k++) begin
                if (k >= top) break;
                a = work_tab[k];
                b = work_tab[top];
                alias_tab[a] = b;
                deficit = sum_w - thr_tab[a];
                if (thr_tab[b] >= deficit) thr_tab[b] = thr_tab[b] - deficit;
                else thr_tab[b] = 0;
                if (thr_tab[b] < sum_w) top++;
                if (top >= n_classes) break;
            end
        end
        tab_ready = 1'b1;
        tables_built++;
    endfunction

    function automatic void model_load(input bit [31:0] w);
        if (loads_seen == 0) begin
            sum_w = 0;
            tab_ready = 1'b0;
        end
        thr_tab[loads_seen % MAX_CLASSES] = 64'(w) * 64'(n_classes);
        sum_w += 64'(w);
        loads_seen++;
        if (loads_seen >= n_classes) begin
            loads_seen = 0;
            build_alias_table();
        end
    endfunction

    function automatic sample_t model_draw(input bit [31:0] u);
        sample_t r;
        bit [63:0] t, f, hi;
        int unsigned k;
        if (!tab_ready || sum_w == 0) begin
            r.class_index = '0;
            r.status = ST_ERR;
            err_samples++;
            return r;
        end
        t  = 64'(u) * 64'(n_classes);
        k  = (t >> 32) % MAX_CLASSES;
        f  = {32'd0, t[31:0]};
        hi = ((f * {32'd0, sum_w[31:0]}) >> 32) + f * (sum_w >> 32);
        r.class_index = (hi < (thr_tab[k] & 64'hFFF_FFFF_FFFF)) ? IDX_W'(k) : alias_tab[k];
        r.status = ST_OK;
        return r;
    endfunction

    // drive one request and hold it until the handshake completes
    task automatic send_req(input logic op, input bit [31:0] w, input bit [31:0] u);
        if (src_idle) begin
            while ($urandom_range(99) < 47) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.weight <= w;
        req_if.uniform_fraction <= u;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
        if (op == OP_LOAD) model_load(w);
        else pending_samples.push_back(model_draw(u));
    endtask

    // wait for every result, then let a possible build finish
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (8 * n_classes + 40) @(posedge i_clk);
    endtask

    task automatic write_class_count(input bit [31:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_CLASS_COUNT, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_classes = clamp_classes(v);
        loads_seen = 0;
        sum_w = 0;
        tab_ready = 1'b0;
    endtask

    function automatic bit [31:0] rand_weight();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(15);
        endcase
    endfunction

    function automatic bit [31:0] rand_fraction();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_req(OP_DRAW, 0, 32'h1234_5678);           // no table yet
        write_class_count(0);                          // acts as one class
        send_req(OP_LOAD, 32'hFFFF_FFFF, 0);
        send_req(OP_DRAW, 0, 32'h0);
        send_req(OP_DRAW, 0, 32'hFFFF_FFFF);
        write_class_count(2);
        send_req(OP_LOAD, 0, 0);
        send_req(OP_DRAW, 0, 32'h8000_0000);           // mid-round draw
        send_req(OP_LOAD, 0, 0);
        send_req(OP_DRAW, 0, 32'h4000_0000);           // zero sum
        write_class_count(3);
        send_req(OP_LOAD, 32'd1, 0);
        send_req(OP_LOAD, 32'hFFFF_FFFF, 0);
        send_req(OP_LOAD, 32'h8000_0000, 0);
        send_req(OP_DRAW, 0, 32'h0);
        send_req(OP_DRAW, 0, 32'hFFFF_FFFF);
        send_req(OP_DRAW, 0, 32'h5555_5555);
        send_req(OP_DRAW, 0, 32'hAAAA_AAAA);
        send_req(OP_DRAW, 0, 32'h8000_0000);
        write_class_count(4);                          // abort a round midway
        send_req(OP_LOAD, 32'd7, 0);
        send_req(OP_LOAD, 32'd9, 0);
        write_class_count(4);
        send_req(OP_DRAW, 0, 32'h2000_0000);
        write_class_count(32'h7FF);                    // clamps to the maximum
        send_req(OP_DRAW, 0, 32'h7FFF_FFFF);
    endtask

    task automatic test_large_table();
        write_class_count(128);
        repeat (128) send_req(OP_LOAD, rand_weight(), 0);
        repeat (16) send_req(OP_DRAW, 0, rand_fraction());
    endtask

    task automatic test_random_phase(input bit idle_in, input bit idle_out,
                                     input int unsigned budget);
        int unsigned start;
        int unsigned n_pick;
        src_idle = idle_in;
        snk_idle = idle_out;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            n_pick = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            write_class_count(n_pick);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(99) < 85) begin
                    repeat (n_classes) send_req(OP_LOAD, rand_weight(), 0);
                    repeat ($urandom_range(3, 8)) send_req(OP_DRAW, 0, rand_fraction());
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_req($urandom_range(1), rand_weight(), rand_fraction());
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.operation = OP_LOAD;
        req_if.weight = '0;
        req_if.uniform_fraction = '0;
        res_if.ready = 1'b0;
        cycles = 0;
        mismatches = 0;
        samples_checked = 0;
        err_samples = 0;
        tables_built = 0;
        requests_sent = 0;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        n_classes = MAX_CLASSES;
        loads_seen = 0;
        sum_w = 0;
        tab_ready = 1'b0;
        for (int i = 0; i < MAX_CLASSES; i++) begin
            thr_tab[i] = 0;
            alias_tab[i] = 0;
            work_tab[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_large_table();
        test_random_phase(1'b0, 1'b0, 75);
        test_random_phase(1'b1, 1'b0, 75);
        test_random_phase(1'b0, 1'b1, 75);
        test_random_phase(1'b1, 1'b1, 75);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        drain();

        $display("covered %0d requests, %0d table builds, class counts 1 to %0d",
                 requests_sent, tables_built, MAX_CLASSES);
        $display("checked %0d samples, %0d with error status, %0d mismatches",
                 samples_checked, err_samples, mismatches);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("alias_table_sampler_core test passed");
        end else begin
            $display("alias_table_sampler_core test failed");
        end
        $finish;
    end

endmodule
